// ===== rtl/ffha_pkg.sv =====
// shared types, codes and constants of the first-fit heap allocator
package ffha_pkg;

	localparam int MAX_BLOCKS_DEF = 256;
	localparam int META_BYTES = 48;
	localparam int ALIGN_BYTES = 4;
	localparam int CNT_W = 9;
	localparam int SIZE_W = 27;
	localparam int RND_W = 28;
	localparam int SCAN_W = 16;

	localparam logic [31:0] HEAP_LIMIT_RST = 32'hFFFF_FFFF;
	localparam logic [26:0] MAX_REQUEST_RST = 27'd100000000;
	localparam logic [15:0] SPLIT_MIN_RST = 16'd128;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_BAD_SIZE = 3'd1,
		ST_NO_HEAP = 3'd2,
		ST_TABLE_FULL = 3'd3,
		ST_BAD_ADDR = 3'd4
	} status_t;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_HEAP_LIMIT = 2'd0,
		CFG_MAX_REQUEST = 2'd1,
		CFG_SPLIT_MIN = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] heap_limit;
		logic [26:0] max_request;
		logic [15:0] split_min;
	} cfg_t;

	typedef struct packed {
		status_t status;
		logic [31:0] payload_addr;
		logic [CNT_W-1:0] free_block_count;
		logic [31:0] free_byte_count;
		logic [CNT_W-1:0] total_block_count;
		logic [31:0] total_byte_count;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_A_WALK,
		S_A_TAILRD,
		S_A_TAIL,
		S_A_APPEND,
		S_A_FIT,
		S_NX,
		S_R_WALK,
		S_R_MATCH,
		S_R_PREV,
		S_WR_FIX,
		S_WR_HOLD,
		S_DONE
	} fsm_t;

endpackage

// ===== rtl/ffha_slot_finder.sv =====
// slot occupancy bits and lowest-free-slot search, one chunk of slots per cycle
module ffha_slot_finder #(
	parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          set_en,
	input  logic [$clog2(MAX_BLOCKS)-1:0] set_idx,
	input  logic                          clr_en,
	input  logic [$clog2(MAX_BLOCKS)-1:0] clr_idx,
	output logic                          done,
	output logic                          found,
	output logic [$clog2(MAX_BLOCKS)-1:0] idx
);
	localparam int SIW = $clog2(MAX_BLOCKS);
	localparam int CH = ffha_pkg::SCAN_W;
	localparam int PEW = $clog2(CH);
	localparam int NCH = (MAX_BLOCKS + CH - 1) / CH;
	localparam int CHW = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int PADW = NCH * CH;

	logic [MAX_BLOCKS-1:0] in_use_q;
	logic [PADW-1:0] pad;
	logic [CH-1:0] chunk;
	logic [CHW-1:0] chunk_q;
	logic busy_q, done_q, found_q;
	logic [SIW-1:0] idx_q;
	logic hit;
	logic [PEW-1:0] pe;
	logic last;

	// slots past the table read as taken
	always_comb begin
		pad = '1;
		pad[MAX_BLOCKS-1:0] = in_use_q;
	end

	assign chunk = pad[chunk_q*CH +: CH];
	assign last = (chunk_q == CHW'(NCH - 1));

	// lowest clear bit of the chunk
	always_comb begin
		hit = 1'b0;
		pe = '0;
		for (int i = CH - 1; i >= 0; i--) begin
			if (!chunk[i]) begin
				hit = 1'b1;
				pe = PEW'(i);
			end
		end
	end

	// scan control and occupancy bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			found_q <= 1'b0;
			chunk_q <= '0;
			idx_q <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				chunk_q <= '0;
			end else if (busy_q) begin
				if (hit) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					found_q <= 1'b1;
					idx_q <= SIW'({chunk_q, pe});
				end else if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					found_q <= 1'b0;
				end else begin
					chunk_q <= chunk_q + CHW'(1);
				end
			end
			if (set_en) begin
				in_use_q[set_idx] <= 1'b1;
				done_q <= 1'b0;
			end
			if (clr_en) begin
				in_use_q[clr_idx] <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign found = found_q;
	assign idx = idx_q;

	a_found_is_free: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && found_q) |-> !in_use_q[idx_q])
		else $error("reported slot is in use");

	a_busy_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !done_q)
		else $error("search busy and done together");

endmodule

// ===== rtl/ffha_ctrl.sv =====
// block table memory and the sequencer for allocate and release
module ffha_ctrl #(
	parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          cmd,
	input  logic [ffha_pkg::SIZE_W-1:0]   request_size,
	input  logic [31:0]                   block_addr,
	input  ffha_pkg::cfg_t                cfg,
	output logic                          idle,
	output logic                          res_valid,
	input  logic                          res_ready,
	output ffha_pkg::res_t                res,
	input  logic                          fnd_done,
	input  logic                          fnd_found,
	input  logic [$clog2(MAX_BLOCKS)-1:0] fnd_idx,
	output logic                          set_en,
	output logic [$clog2(MAX_BLOCKS)-1:0] set_idx,
	output logic                          clr_en,
	output logic [$clog2(MAX_BLOCKS)-1:0] clr_idx
);
	localparam int SIW = $clog2(MAX_BLOCKS);
	localparam int SW = SIW + 1;
	localparam int RW = ffha_pkg::RND_W;
	localparam int CW = ffha_pkg::CNT_W;
	localparam logic [SW-1:0] NIL = SW'(MAX_BLOCKS);
	localparam logic [31:0] META = 32'(ffha_pkg::META_BYTES);
	localparam logic [RW-1:0] AMASK = RW'(ffha_pkg::ALIGN_BYTES - 1);

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] size;
		logic        free;
		logic [SW-1:0] next;
		logic [SW-1:0] prev;
	} entry_t;

	function automatic logic is_slot(input logic [SW-1:0] l);
		return l < NIL;
	endfunction

	// block table
	entry_t blk_mem_q [MAX_BLOCKS];
	entry_t rd_data_q;
	logic rd_en, wr_en;
	logic [SIW-1:0] rd_addr, wr_addr;
	entry_t wr_data;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= blk_mem_q[rd_addr];
		end
		if (wr_en) begin
			blk_mem_q[wr_addr] <= wr_data;
		end
	end

	// control state
	ffha_pkg::fsm_t state_q, state_d;
	logic [SW-1:0] head_q, head_d, tail_q, tail_d;
	logic [31:0] heap_top_q, heap_top_d;
	logic [CW-1:0] fbk_q, fbk_d, tbk_q, tbk_d;
	logic [31:0] fby_q, fby_d, tby_q, tby_d;

	// per-item working registers
	ffha_pkg::cmd_t cmd_q, cmd_d;
	ffha_pkg::status_t status_q, status_d;
	logic bad_q, bad_d;
	logic [RW-1:0] r_q, r_d;
	logic [31:0] baddr_q, baddr_d, addr_q, addr_d;
	logic [SW-1:0] cur_q, cur_d, wslot_q, wslot_d, hold_slot_q, hold_slot_d;
	logic [SW-1:0] fix_slot_q, fix_slot_d, fixval_q, fixval_d;
	logic pabs_q, pabs_d;
	entry_t e_q, e_d, w_q, w_d, hold_q, hold_d;

	// datapath terms
	entry_t rdata;
	logic [31:0] r32, diff, grow;
	logic [RW:0] rsum;
	logic split_want, grow_over, app_over, match;
	logic [SW-1:0] s_new;

	assign rdata = rd_data_q;
	assign r32 = {{(32 - RW){1'b0}}, r_q};
	assign diff = e_q.size - r32;
	assign split_want = {1'b0, diff} >= ({17'b0, cfg.split_min} + {1'b0, META});
	assign grow = r32 - rdata.size;
	assign grow_over = ({1'b0, heap_top_q} + {1'b0, grow}) > {1'b0, cfg.heap_limit};
	assign app_over = ({1'b0, heap_top_q} + {1'b0, META} + {1'b0, r32})
		> {1'b0, cfg.heap_limit};
	assign match = ({1'b0, rdata.start} + {1'b0, META}) == {1'b0, baddr_q};
	assign s_new = {1'b0, fnd_idx};
	assign rsum = {1'b0, request_size} + {1'b0, AMASK};

	// next state, memory accesses and bookkeeping
	always_comb begin
		entry_t wn;
		logic [SW-1:0] wslot;

		state_d = state_q;
		head_d = head_q;
		tail_d = tail_q;
		heap_top_d = heap_top_q;
		fbk_d = fbk_q;
		tbk_d = tbk_q;
		fby_d = fby_q;
		tby_d = tby_q;
		cmd_d = cmd_q;
		status_d = status_q;
		bad_d = bad_q;
		r_d = r_q;
		baddr_d = baddr_q;
		addr_d = addr_q;
		cur_d = cur_q;
		wslot_d = wslot_q;
		hold_slot_d = hold_slot_q;
		fix_slot_d = fix_slot_q;
		fixval_d = fixval_q;
		pabs_d = pabs_q;
		e_d = e_q;
		w_d = w_q;
		hold_d = hold_q;
		rd_en = 1'b0;
		rd_addr = '0;
		wr_en = 1'b0;
		wr_addr = '0;
		wr_data = w_q;
		set_en = 1'b0;
		set_idx = fnd_idx;
		clr_en = 1'b0;
		clr_idx = '0;
		res_valid = 1'b0;
		wn = w_q;
		wslot = wslot_q;

		unique case (state_q)
			ffha_pkg::S_IDLE: begin
				if (start) begin
					cmd_d = ffha_pkg::cmd_t'(cmd);
					r_d = rsum[RW-1:0] & ~AMASK;
					bad_d = (request_size == '0) || (request_size > cfg.max_request);
					baddr_d = block_addr;
					status_d = ffha_pkg::ST_OK;
					addr_d = '0;
					state_d = ffha_pkg::S_START;
				end
			end
			ffha_pkg::S_START: begin
				if (cmd_q == ffha_pkg::CMD_ALLOC) begin
					if (bad_q) begin
						status_d = ffha_pkg::ST_BAD_SIZE;
						state_d = ffha_pkg::S_DONE;
					end else if (is_slot(head_q)) begin
						rd_en = 1'b1;
						rd_addr = head_q[SIW-1:0];
						cur_d = head_q;
						state_d = ffha_pkg::S_A_WALK;
					end else begin
						state_d = ffha_pkg::S_A_TAILRD;
					end
				end else begin
					if (is_slot(head_q)) begin
						rd_en = 1'b1;
						rd_addr = head_q[SIW-1:0];
						cur_d = head_q;
						state_d = ffha_pkg::S_R_WALK;
					end else begin
						status_d = ffha_pkg::ST_BAD_ADDR;
						state_d = ffha_pkg::S_DONE;
					end
				end
			end
			// first-fit walk, one block per cycle
			ffha_pkg::S_A_WALK: begin
				if (rdata.free && (r32 <= rdata.size)) begin
					e_d = rdata;
					state_d = ffha_pkg::S_A_FIT;
				end else if (is_slot(rdata.next)) begin
					rd_en = 1'b1;
					rd_addr = rdata.next[SIW-1:0];
					cur_d = rdata.next;
				end else begin
					state_d = ffha_pkg::S_A_TAILRD;
				end
			end
			ffha_pkg::S_A_TAILRD: begin
				if (is_slot(tail_q)) begin
					rd_en = 1'b1;
					rd_addr = tail_q[SIW-1:0];
					state_d = ffha_pkg::S_A_TAIL;
				end else begin
					state_d = ffha_pkg::S_A_APPEND;
				end
			end
			// grow a free tail block in place
			ffha_pkg::S_A_TAIL: begin
				e_d = rdata;
				if (rdata.free && (r32 > rdata.size)) begin
					if (grow_over) begin
						status_d = ffha_pkg::ST_NO_HEAP;
					end else begin
						wn = rdata;
						wn.size = r32;
						wn.free = 1'b0;
						wr_en = 1'b1;
						wr_addr = tail_q[SIW-1:0];
						wr_data = wn;
						heap_top_d = heap_top_q + grow;
						fbk_d = fbk_q - CW'(1);
						fby_d = fby_q - rdata.size;
						tby_d = tby_q + grow;
						addr_d = rdata.start + META;
					end
					state_d = ffha_pkg::S_DONE;
				end else begin
					state_d = ffha_pkg::S_A_APPEND;
				end
			end
			// new block at the heap top
			ffha_pkg::S_A_APPEND: begin
				if (fnd_done) begin
					if (!fnd_found) begin
						status_d = ffha_pkg::ST_TABLE_FULL;
						state_d = ffha_pkg::S_DONE;
					end else if (app_over) begin
						status_d = ffha_pkg::ST_NO_HEAP;
						state_d = ffha_pkg::S_DONE;
					end else begin
						wn.start = heap_top_q;
						wn.size = r32;
						wn.free = 1'b0;
						wn.next = NIL;
						wn.prev = tail_q;
						wr_en = 1'b1;
						wr_addr = fnd_idx;
						wr_data = wn;
						set_en = 1'b1;
						tail_d = s_new;
						heap_top_d = heap_top_q + META + r32;
						tbk_d = tbk_q + CW'(1);
						tby_d = tby_q + r32;
						addr_d = heap_top_q + META;
						if (is_slot(tail_q)) begin
							hold_d = e_q;
							hold_d.next = s_new;
							hold_slot_d = tail_q;
							state_d = ffha_pkg::S_WR_HOLD;
						end else begin
							head_d = s_new;
							state_d = ffha_pkg::S_DONE;
						end
					end
				end
			end
			// take the fitting block, split off the leftover when it pays
			ffha_pkg::S_A_FIT: begin
				if (!(split_want && !fnd_done)) begin
					addr_d = e_q.start + META;
					fbk_d = fbk_q - CW'(1);
					wn = e_q;
					wn.free = 1'b0;
					wr_en = 1'b1;
					wr_addr = cur_q[SIW-1:0];
					if (split_want && fnd_found) begin
						// the leftover stays free, so the free count holds
						fbk_d = fbk_q;
						wn.size = r32;
						wn.next = s_new;
						wr_data = wn;
						fby_d = fby_q - r32 - META;
						tbk_d = tbk_q + CW'(1);
						tby_d = tby_q - META;
						set_en = 1'b1;
						w_d.start = e_q.start + META + r32;
						w_d.size = diff - META;
						w_d.free = 1'b1;
						w_d.next = e_q.next;
						w_d.prev = cur_q;
						wslot_d = s_new;
						pabs_d = 1'b1;
						if (is_slot(e_q.next)) begin
							rd_en = 1'b1;
							rd_addr = e_q.next[SIW-1:0];
							state_d = ffha_pkg::S_NX;
						end else begin
							tail_d = s_new;
							hold_d = w_d;
							hold_slot_d = s_new;
							state_d = ffha_pkg::S_WR_HOLD;
						end
					end else begin
						wr_data = wn;
						fby_d = fby_q - e_q.size;
						state_d = ffha_pkg::S_DONE;
					end
				end
			end
			// write back the working block, merging a free successor into it
			ffha_pkg::S_NX: begin
				wr_en = 1'b1;
				wr_addr = wslot_q[SIW-1:0];
				if (rdata.free) begin
					wn.size = w_q.size + META + rdata.size;
					wn.next = rdata.next;
					wr_data = wn;
					clr_en = 1'b1;
					clr_idx = w_q.next[SIW-1:0];
					fbk_d = fbk_q - CW'(1);
					tbk_d = tbk_q - CW'(1);
					fby_d = fby_q + META;
					tby_d = tby_q + META;
					if (is_slot(rdata.next)) begin
						rd_en = 1'b1;
						rd_addr = rdata.next[SIW-1:0];
						fix_slot_d = rdata.next;
						fixval_d = wslot_q;
						state_d = ffha_pkg::S_WR_FIX;
					end else begin
						tail_d = wslot_q;
						state_d = ffha_pkg::S_DONE;
					end
				end else begin
					wr_data = w_q;
					if (pabs_q) begin
						hold_d = rdata;
						hold_d.prev = wslot_q;
						hold_slot_d = w_q.next;
						state_d = ffha_pkg::S_WR_HOLD;
					end else begin
						state_d = ffha_pkg::S_DONE;
					end
				end
			end
			ffha_pkg::S_WR_FIX: begin
				wn = rdata;
				wn.prev = fixval_q;
				wr_en = 1'b1;
				wr_addr = fix_slot_q[SIW-1:0];
				wr_data = wn;
				state_d = ffha_pkg::S_DONE;
			end
			ffha_pkg::S_WR_HOLD: begin
				wr_en = 1'b1;
				wr_addr = hold_slot_q[SIW-1:0];
				wr_data = hold_q;
				state_d = ffha_pkg::S_DONE;
			end
			// address search for a release
			ffha_pkg::S_R_WALK: begin
				if (match) begin
					e_d = rdata;
					state_d = ffha_pkg::S_R_MATCH;
				end else if (is_slot(rdata.next)) begin
					rd_en = 1'b1;
					rd_addr = rdata.next[SIW-1:0];
					cur_d = rdata.next;
				end else begin
					status_d = ffha_pkg::ST_BAD_ADDR;
					state_d = ffha_pkg::S_DONE;
				end
			end
			ffha_pkg::S_R_MATCH: begin
				if (!e_q.free) begin
					fbk_d = fbk_q + CW'(1);
					fby_d = fby_q + e_q.size;
				end
				wn = e_q;
				wn.free = 1'b1;
				w_d = wn;
				wslot_d = cur_q;
				pabs_d = 1'b0;
				if (is_slot(e_q.prev)) begin
					rd_en = 1'b1;
					rd_addr = e_q.prev[SIW-1:0];
					state_d = ffha_pkg::S_R_PREV;
				end else if (is_slot(e_q.next)) begin
					rd_en = 1'b1;
					rd_addr = e_q.next[SIW-1:0];
					state_d = ffha_pkg::S_NX;
				end else begin
					wr_en = 1'b1;
					wr_addr = cur_q[SIW-1:0];
					wr_data = wn;
					state_d = ffha_pkg::S_DONE;
				end
			end
			// a free predecessor takes in the released block
			ffha_pkg::S_R_PREV: begin
				if (rdata.free) begin
					wn = rdata;
					wn.size = rdata.size + META + w_q.size;
					wn.next = w_q.next;
					wslot = e_q.prev;
					pabs_d = 1'b1;
					clr_en = 1'b1;
					clr_idx = cur_q[SIW-1:0];
					fbk_d = fbk_q - CW'(1);
					tbk_d = tbk_q - CW'(1);
					fby_d = fby_q + META;
					tby_d = tby_q + META;
					if (!is_slot(w_q.next)) begin
						tail_d = e_q.prev;
					end
				end
				w_d = wn;
				wslot_d = wslot;
				if (is_slot(w_q.next)) begin
					rd_en = 1'b1;
					rd_addr = w_q.next[SIW-1:0];
					state_d = ffha_pkg::S_NX;
				end else begin
					wr_en = 1'b1;
					wr_addr = wslot[SIW-1:0];
					wr_data = wn;
					state_d = ffha_pkg::S_DONE;
				end
			end
			ffha_pkg::S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ffha_pkg::S_IDLE;
				end
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffha_pkg::S_IDLE;
			head_q <= NIL;
			tail_q <= NIL;
			heap_top_q <= '0;
			fbk_q <= '0;
			tbk_q <= '0;
			fby_q <= '0;
			tby_q <= '0;
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			tail_q <= tail_d;
			heap_top_q <= heap_top_d;
			fbk_q <= fbk_d;
			tbk_q <= tbk_d;
			fby_q <= fby_d;
			tby_q <= tby_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
		status_q <= status_d;
		bad_q <= bad_d;
		r_q <= r_d;
		baddr_q <= baddr_d;
		addr_q <= addr_d;
		cur_q <= cur_d;
		wslot_q <= wslot_d;
		hold_slot_q <= hold_slot_d;
		fix_slot_q <= fix_slot_d;
		fixval_q <= fixval_d;
		pabs_q <= pabs_d;
		e_q <= e_d;
		w_q <= w_d;
		hold_q <= hold_d;
	end

	assign idle = (state_q == ffha_pkg::S_IDLE);
	assign res.status = status_q;
	assign res.payload_addr = addr_q;
	assign res.free_block_count = fbk_q;
	assign res.free_byte_count = fby_q;
	assign res.total_block_count = tbk_q;
	assign res.total_byte_count = tby_q;

	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffha_pkg::S_DONE && status_q != ffha_pkg::ST_OK) |-> (addr_q == '0))
		else $error("failed item carries an address");

	a_set_clr_apart: assert property (@(posedge clk) disable iff (!arst_n)
		set_en |-> !clr_en)
		else $error("slot set and cleared in one cycle");

	a_head_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == NIL) |-> (tail_q == NIL))
		else $error("tail set while list is empty");

endmodule

// ===== rtl/first_fit_heap_allocator_top.sv =====
// A bad size or a release on an empty table ends without a walk; an allocate or a release
// walks the block list of the table
// (one block per cycle from the block memory read port).
// Throughput: one item at a time; the next item is taken once the result is in the output
// register. A split or append may wait on the free-slot search, which runs alongside
// the walk.
module first_fit_heap_allocator_top #(
	parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [1:0]                  cfg_index,
	input  logic [31:0]                 cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        cmd,
	input  logic [ffha_pkg::SIZE_W-1:0] request_size,
	input  logic [31:0]                 block_addr,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  status,
	output logic [31:0]                 payload_addr,
	output logic [ffha_pkg::CNT_W-1:0]  free_block_count,
	output logic [31:0]                 free_byte_count,
	output logic [ffha_pkg::CNT_W-1:0]  total_block_count,
	output logic [31:0]                 total_byte_count
);
	localparam int SIW = $clog2(MAX_BLOCKS);

	ffha_pkg::cfg_t cfg_q;
	ffha_pkg::res_t res, out_q;
	logic out_valid_q;
	logic idle, start, res_valid, res_ready;
	logic fnd_done, fnd_found, set_en, clr_en;
	logic [SIW-1:0] fnd_idx, set_idx, clr_idx;

	// configuration registers; reset clears slot bits, list ends, heap top and counts at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.heap_limit <= ffha_pkg::HEAP_LIMIT_RST;
			cfg_q.max_request <= ffha_pkg::MAX_REQUEST_RST;
			cfg_q.split_min <= ffha_pkg::SPLIT_MIN_RST;
		end else if (cfg_wr_en) begin
			unique case (ffha_pkg::cfg_reg_t'(cfg_index))
				ffha_pkg::CFG_HEAP_LIMIT: cfg_q.heap_limit <= cfg_wdata;
				ffha_pkg::CFG_MAX_REQUEST: cfg_q.max_request <= cfg_wdata[26:0];
				ffha_pkg::CFG_SPLIT_MIN: cfg_q.split_min <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign in_ready = idle;
	assign start = in_valid && idle;
	assign res_ready = !out_valid_q || out_ready;

	ffha_slot_finder #(.MAX_BLOCKS(MAX_BLOCKS)) u_finder (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.set_en  (set_en),
		.set_idx (set_idx),
		.clr_en  (clr_en),
		.clr_idx (clr_idx),
		.done    (fnd_done),
		.found   (fnd_found),
		.idx     (fnd_idx)
	);

	ffha_ctrl #(.MAX_BLOCKS(MAX_BLOCKS)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.cmd          (cmd),
		.request_size (request_size),
		.block_addr   (block_addr),
		.cfg          (cfg_q),
		.idle         (idle),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.fnd_done     (fnd_done),
		.fnd_found    (fnd_found),
		.fnd_idx      (fnd_idx),
		.set_en       (set_en),
		.set_idx      (set_idx),
		.clr_en       (clr_en),
		.clr_idx      (clr_idx)
	);

	// output item register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_q.status;
	assign payload_addr = out_q.payload_addr;
	assign free_block_count = out_q.free_block_count;
	assign free_byte_count = out_q.free_byte_count;
	assign total_block_count = out_q.total_block_count;
	assign total_byte_count = out_q.total_byte_count;

endmodule

// ===== test/tb.sv =====
// testbench of the first-fit heap allocator: directed rows, then random phases
module tb;
	import ffha_pkg::*;

	localparam int NBLK = 256;
	localparam int DRAIN_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		cmd_t c;
		logic [26:0] sz;
		logic [31:0] ad;
		bit typed;
		status_t st;
		logic [31:0] pa;
	} dir_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_wr_en = 0;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_wdata = '0;
	logic in_valid = 0;
	logic in_ready;
	logic cmd = 0;
	logic [SIZE_W-1:0] request_size = '0;
	logic [31:0] block_addr = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [2:0] status;
	logic [31:0] payload_addr;
	logic [CNT_W-1:0] free_block_count;
	logic [31:0] free_byte_count;
	logic [CNT_W-1:0] total_block_count;
	logic [31:0] total_byte_count;

	// row-typed expectation travelling with the item
	logic cur_typed = 0;
	status_t cur_st = ST_OK;
	logic [31:0] cur_pa = '0;

	first_fit_heap_allocator_top dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// shadow heap table
	logic [31:0] h_start [NBLK];
	logic [31:0] h_size [NBLK];
	bit h_free [NBLK];
	int h_next [NBLK];
	int h_prev [NBLK];
	bit h_used [NBLK];
	int h_head = NBLK;
	int h_tail = NBLK;
	logic [31:0] h_top = 0;
	logic [31:0] lim = HEAP_LIMIT_RST;
	logic [26:0] maxreq = MAX_REQUEST_RST;
	logic [15:0] smin = SPLIT_MIN_RST;

	res_t expected_results [$];
	logic [31:0] granted_addrs [$];
	int errors = 0;
	int items_in = 0;
	int results_out = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_cnt = 0;
	bit hold_req = 0;
	int quiet_cycles = 0;

	function automatic int lowest_slot();
		for (int i = 0; i < NBLK; i++)
			if (!h_used[i]) return i;
		return NBLK;
	endfunction

	function automatic void join_next(int a);
		int b, c;
		b = h_next[a];
		if (b >= NBLK) return;
		h_size[a] = h_size[a] + META_BYTES + h_size[b];
		c = h_next[b];
		h_next[a] = c;
		if (c < NBLK) h_prev[c] = a;
		else h_tail = a;
		h_used[b] = 0;
	endfunction

	function automatic status_t alloc_block(logic [26:0] req, output logic [31:0] addr);
		longint r;
		int cur, s, nx, t;
		addr = 0;
		if (req == 0 || req > maxreq) return ST_BAD_SIZE;
		r = (longint'(req) + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
		cur = h_head;
		// first fit walk
		while (cur < NBLK) begin
			if (h_free[cur] && r <= h_size[cur]) begin
				h_free[cur] = 0;
				if (longint'(h_size[cur]) - r >= longint'(smin) + META_BYTES) begin
					s = lowest_slot();
					if (s < NBLK) begin
						nx = h_next[cur];
						h_start[s] = h_start[cur] + META_BYTES + r[31:0];
						h_size[s] = h_size[cur] - r[31:0] - META_BYTES;
						h_free[s] = 1;
						h_used[s] = 1;
						h_next[s] = nx;
						h_prev[s] = cur;
						if (nx < NBLK) h_prev[nx] = s;
						else h_tail = s;
						h_next[cur] = s;
						h_size[cur] = r[31:0];
						if (nx < NBLK && h_free[nx]) join_next(s);
					end
				end
				addr = h_start[cur] + META_BYTES;
				return ST_OK;
			end
			cur = h_next[cur];
		end
		// grow a free tail
		t = h_tail;
		if (t < NBLK && h_free[t] && r > h_size[t]) begin
			if (longint'(h_top) + r - h_size[t] > longint'(lim)) return ST_NO_HEAP;
			h_top = h_top + r[31:0] - h_size[t];
			h_size[t] = r[31:0];
			h_free[t] = 0;
			addr = h_start[t] + META_BYTES;
			return ST_OK;
		end
		// append at heap top
		s = lowest_slot();
		if (s >= NBLK) return ST_TABLE_FULL;
		if (longint'(h_top) + META_BYTES + r > longint'(lim)) return ST_NO_HEAP;
		h_start[s] = h_top;
		h_size[s] = r[31:0];
		h_free[s] = 0;
		h_used[s] = 1;
		h_next[s] = NBLK;
		h_prev[s] = t;
		if (t < NBLK) h_next[t] = s;
		else h_head = s;
		h_tail = s;
		h_top = h_top + META_BYTES + r[31:0];
		addr = h_start[s] + META_BYTES;
		return ST_OK;
	endfunction

	function automatic status_t release_block(logic [31:0] a);
		int cur, p, nx;
		cur = h_head;
		while (cur < NBLK) begin
			if (longint'(h_start[cur]) + META_BYTES == longint'(a)) break;
			cur = h_next[cur];
		end
		if (cur >= NBLK) return ST_BAD_ADDR;
		p = h_prev[cur];
		if (p < NBLK && h_free[p]) begin
			join_next(p);
			cur = p;
		end
		nx = h_next[cur];
		if (nx < NBLK && h_free[nx]) join_next(cur);
		h_free[cur] = 1;
		return ST_OK;
	endfunction

	function automatic res_t heap_step(logic c, logic [26:0] sz, logic [31:0] ad);
		res_t r;
		int cur;
		logic [31:0] a;
		a = 0;
		if (c == CMD_ALLOC) r.status = alloc_block(sz, a);
		else r.status = release_block(ad);
		if (r.status != ST_OK) a = 0;
		if (c == CMD_ALLOC && r.status == ST_OK) begin
			granted_addrs.push_back(a);
			if (granted_addrs.size() > 400) void'(granted_addrs.pop_front());
		end
		r.payload_addr = a;
		r.free_block_count = 0;
		r.free_byte_count = 0;
		r.total_block_count = 0;
		r.total_byte_count = 0;
		cur = h_head;
		while (cur < NBLK) begin
			r.total_block_count++;
			r.total_byte_count += h_size[cur];
			if (h_free[cur]) begin
				r.free_block_count++;
				r.free_byte_count += h_size[cur];
			end
			cur = h_next[cur];
		end
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$display("%0t mismatch %s: expected %0h actual %0h", $time, name, e, a);
			errors++;
		end
	endfunction

	// accept items, predict, and check results
	always @(posedge clk) begin
		res_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_out++;
				if (expected_results.size() == 0) begin
					$display("%0t unexpected result: expected none actual status %0d", $time,
						status);
					errors++;
				end else begin
					e = expected_results.pop_front();
					check_field("status", e.status, status);
					check_field("payload_addr", e.payload_addr, payload_addr);
					check_field("free_block_count", e.free_block_count, free_block_count);
					check_field("free_byte_count", e.free_byte_count, free_byte_count);
					check_field("total_block_count", e.total_block_count, total_block_count);
					check_field("total_byte_count", e.total_byte_count, total_byte_count);
				end
			end
			if (in_valid && in_ready) begin
				items_in++;
				e = heap_step(cmd, request_size, block_addr);
				if (cur_typed) begin
					e.status = cur_st;
					e.payload_addr = cur_pa;
				end
				expected_results.push_back(e);
			end
		end
	end

	// receiver: random stalls plus a long hold-off when requested
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			hold_cnt = 600;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t watchdog: no progress, %0d results outstanding", $time,
				expected_results.size());
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_item(cmd_t c, logic [26:0] sz, logic [31:0] ad, bit typed = 0,
		status_t st = ST_OK, logic [31:0] pa = 0);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
		in_valid <= 1;
		cmd <= c;
		request_size <= sz;
		block_addr <= ad;
		cur_typed <= typed;
		cur_st <= st;
		cur_pa <= pa;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(logic [31:0] hl, logic [26:0] mr, logic [15:0] sm);
		@(posedge clk);
		cfg_wr_en <= 1;
		cfg_index <= CFG_HEAP_LIMIT;
		cfg_wdata <= hl;
		@(posedge clk);
		cfg_index <= CFG_MAX_REQUEST;
		cfg_wdata <= {5'b0, mr};
		@(posedge clk);
		cfg_index <= CFG_SPLIT_MIN;
		cfg_wdata <= {16'b0, sm};
		@(posedge clk);
		cfg_wr_en <= 0;
		lim = hl;
		maxreq = mr;
		smin = sm;
	endtask

	// one random item: mostly allocations and releases of granted addresses
	task automatic random_item();
		int k;
		logic [26:0] sz;
		logic [31:0] ad;
		k = $urandom_range(99);
		ad = $urandom;
		if (k < 55) begin
			k = $urandom_range(99);
			if (k < 70) sz = 27'($urandom_range(300, 1));
			else if (k < 80) sz = 27'($urandom_range(maxreq, 1));
			else if (k < 90) sz = 27'($urandom);
			else if (k < 95) sz = 0;
			else sz = (maxreq == 27'h7FF_FFFF) ? maxreq : maxreq + 27'd1;
			send_item(CMD_ALLOC, sz, ad);
		end else if (k < 90 && granted_addrs.size() > 0) begin
			ad = granted_addrs[$urandom_range(granted_addrs.size() - 1)];
			send_item(CMD_FREE, 27'($urandom), ad);
		end else begin
			send_item(CMD_FREE, 27'($urandom), ad);
		end
	endtask

	dir_row_t dir_rows [] = '{
		'{CMD_ALLOC, 27'd0, 32'h0, 1, ST_BAD_SIZE, 32'h0},
		'{CMD_ALLOC, 27'h7FF_FFFF, 32'hFFFF_FFFF, 1, ST_BAD_SIZE, 32'h0},
		'{CMD_FREE, 27'h7FF_FFFF, 32'h0, 1, ST_BAD_ADDR, 32'h0},
		'{CMD_ALLOC, 27'd1, 32'h0, 1, ST_OK, 32'd48},
		'{CMD_ALLOC, 27'd100, 32'h0, 1, ST_OK, 32'd100},
		'{CMD_FREE, 27'd0, 32'd48, 1, ST_OK, 32'h0},
		'{CMD_FREE, 27'd0, 32'd48, 1, ST_OK, 32'h0},
		'{CMD_ALLOC, 27'd3, 32'h0, 1, ST_OK, 32'd48},
		'{CMD_FREE, 27'd0, 32'hFFFF_FFFF, 1, ST_BAD_ADDR, 32'h0},
		'{CMD_ALLOC, 27'd100000000, 32'h0, 0, ST_OK, 32'h0},
		'{CMD_ALLOC, 27'd100000001, 32'h0, 1, ST_BAD_SIZE, 32'h0},
		'{CMD_FREE, 27'd0, 32'd100, 0, ST_OK, 32'h0},
		'{CMD_ALLOC, 27'd10, 32'h0, 0, ST_OK, 32'h0},
		'{CMD_ALLOC, 27'd2000, 32'h0, 0, ST_OK, 32'h0},
		'{CMD_FREE, 27'd0, 32'd48, 0, ST_OK, 32'h0},
		'{CMD_ALLOC, 27'd5, 32'h0, 0, ST_OK, 32'h0},
		'{CMD_ALLOC, 27'd99999999, 32'h0, 0, ST_OK, 32'h0},
		'{CMD_FREE, 27'd0, 32'd49, 0, ST_OK, 32'h0},
		'{CMD_ALLOC, 27'd7, 32'h0, 0, ST_OK, 32'h0}
	};

	initial begin
		int n;
		for (int i = 0; i < NBLK; i++) begin
			h_used[i] = 0;
			h_free[i] = 0;
			h_next[i] = NBLK;
			h_prev[i] = NBLK;
			h_start[i] = 0;
			h_size[i] = 0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed rows with reset settings
		foreach (dir_rows[i])
			send_item(dir_rows[i].c, dir_rows[i].sz, dir_rows[i].ad, dir_rows[i].typed,
				dir_rows[i].st, dir_rows[i].pa);
		cur_typed <= 0;
		drain();

		// tight splits and widest requests, sender idling
		write_cfg(32'hFFFF_FFFF, 27'h7FF_FFFF, 16'd0);
		idle_pct = 54;
		stall_pct = 0;
		n = 0;
		while (n < 260) begin
			if ($urandom_range(99) < 70)
				send_item(CMD_ALLOC, 27'($urandom_range(16, 1)), $urandom);
			else random_item();
			n++;
		end
		drain();

		// largest split minimum, receiver stalling with a long hold-off
		write_cfg(32'hFFFF_FFFF, MAX_REQUEST_RST, 16'hFFFF);
		idle_pct = 0;
		stall_pct = 54;
		hold_req = 1;
		repeat (150) random_item();
		drain();

		// heap limit just above the current top, both sides idling
		write_cfg(h_top + 32'd5000, MAX_REQUEST_RST, SPLIT_MIN_RST);
		idle_pct = 18;
		stall_pct = 18;
		repeat (150) random_item();
		drain();

		// zero heap limit and a one-byte request cap
		write_cfg(32'h0, 27'd1, 16'd64);
		idle_pct = 0;
		stall_pct = 0;
		repeat (60) random_item();
		drain();

		// back to reset values, no idling, then both
		write_cfg(HEAP_LIMIT_RST, MAX_REQUEST_RST, SPLIT_MIN_RST);
		repeat (150) random_item();
		idle_pct = 18;
		stall_pct = 18;
		repeat (150) random_item();
		drain();

		$display("tb: %0d items sent, %0d results checked, %0d mismatches", items_in,
			results_out, errors);
		$display("tb: covered bad sizes, splits, coalescing, tail growth, full table, limits");
		if (errors == 0 && expected_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/ffha_pkg.sv
rtl/ffha_slot_finder.sv
rtl/ffha_ctrl.sv
rtl/first_fit_heap_allocator_top.sv
test/tb.sv
